FILE: rtl/core/single_buffer_slot_relay_defines.svh
// assertion macros for the slot relay checker
`ifndef SINGLE_BUFFER_SLOT_RELAY_DEFINES_SVH
`define SINGLE_BUFFER_SLOT_RELAY_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SRLY_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot relay check failed");

// next-cycle implication, off while reset is held
`define SRLY_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot relay check failed");

// next-cycle implication that also covers the reset cycles
`define SRLY_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("slot relay check failed");

`endif

FILE: rtl/core/srly_pkg.sv
// types and constants shared by the slot relay modules
`timescale 1ns / 1ps
`default_nettype none
package srly_pkg;

    localparam int LEN_W  = 8;
    localparam int BODY_W = 64;
    localparam int DATA_W = LEN_W + BODY_W;
    localparam int USER_W = 3;
    localparam int RUN_MAX = 3;

    typedef enum logic {
        DEST_DEV = 1'b0,
        DEST_HUB = 1'b1
    } t_dest;

    typedef enum logic [1:0] {
        IN_READY = 2'd0,
        IN_DATA  = 2'd1,
        IN_GRANT = 2'd2,
        IN_OTHER = 2'd3
    } t_in_kind;

    typedef enum logic [1:0] {
        SEND_PROBE = 2'd0,
        SEND_SLOT  = 2'd1,
        SEND_DONE  = 2'd2,
        SEND_DATA  = 2'd3
    } t_send_kind;

    typedef struct packed {
        t_dest              req_type;
        t_in_kind           packet_kind;
        logic [LEN_W-1:0]   packet_length;
        logic [BODY_W-1:0]  packet_body;
    } t_item;

    typedef struct packed {
        t_dest              dest;
        t_send_kind         kind;
        logic [LEN_W-1:0]   len;
        logic [BODY_W-1:0]  body;
    } t_res;

    // one item's worth of results handed to the output sequencer
    typedef struct packed {
        logic               load;
        logic [1:0]         cnt;
        t_res [RUN_MAX-1:0] ent;
    } t_run;

endpackage
`default_nettype wire

FILE: rtl/core/srly_in_stage.sv
// input register stage of the slot relay
`timescale 1ns / 1ps
`default_nettype none
module srly_in_stage
    import srly_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic [USER_W-1:0] i_user,
    output logic                   o_item_valid,
    output t_item                  o_item,
    input  wire logic              i_take
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_item.req_type      = t_dest'(i_user[0]);
        n_item.packet_kind   = t_in_kind'(i_user[2:1]);
        n_item.packet_length = i_data[LEN_W-1:0];
        n_item.packet_body   = i_data[DATA_W-1:LEN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/srly_core.sv
// relay state and per-packet decision logic
`timescale 1ns / 1ps
`default_nettype none
module srly_core
    import srly_pkg::*;
#(
    parameter int BODY_BITS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_take,
    input  wire logic  i_seq_free,
    output t_run       o_run
);

    localparam logic [BODY_W-1:0] BODY_MASK = {BODY_W{1'b1}} >> (BODY_W - BODY_BITS);

    logic                 r_link;
    logic                 r_full;
    logic                 r_asked;
    logic [LEN_W-1:0]     r_held_len;
    logic [BODY_BITS-1:0] r_held_body;
    logic                 n_link;
    logic                 n_full;
    logic                 n_asked;
    logic                 fill;
    t_run                 run;

    function automatic t_res mk_res(t_dest d, t_send_kind k,
                                    logic [LEN_W-1:0] l, logic [BODY_W-1:0] b);
        t_res r;
        r.dest = d;
        r.kind = k;
        r.len  = l;
        r.body = b;
        return r;
    endfunction

    assign o_take = i_item_valid && i_seq_free;

    always_comb begin
        n_link  = r_link;
        n_full  = r_full;
        n_asked = r_asked;
        fill    = 1'b0;
        run     = '0;
        if (i_item.req_type == DEST_DEV) begin
            if (i_item.packet_kind == IN_READY) begin
                n_link = 1'b1;
                if (!r_link) begin
                    // waking up with a held packet: no poll yet
                    if (!r_full) begin
                        run.cnt    = 2'd1;
                        run.ent[0] = mk_res(DEST_DEV, SEND_PROBE, '0, '0);
                    end
                end else begin
                    n_full     = 1'b0;
                    n_asked    = 1'b0;
                    run.cnt    = 2'd1;
                    run.ent[0] = mk_res(DEST_DEV, SEND_PROBE, '0, '0);
                end
            end else if (i_item.packet_kind == IN_DATA) begin
                n_link = 1'b1;
                if (!r_full) begin
                    fill   = 1'b1;
                    n_full = 1'b1;
                    if (!r_asked) begin
                        n_asked    = 1'b1;
                        run.cnt    = 2'd1;
                        run.ent[0] = mk_res(DEST_HUB, SEND_SLOT, '0, '0);
                    end
                end
            end
        end else if (r_link) begin
            if (i_item.packet_kind == IN_GRANT) begin
                n_asked = 1'b0;
                n_full  = 1'b0;
                if (r_full) begin
                    run.cnt    = 2'd3;
                    run.ent[0] = mk_res(DEST_HUB, SEND_DATA, r_held_len,
                                        BODY_W'(r_held_body));
                    run.ent[1] = mk_res(DEST_HUB, SEND_DONE, '0, '0);
                    run.ent[2] = mk_res(DEST_DEV, SEND_PROBE, '0, '0);
                end else begin
                    run.cnt    = 2'd2;
                    run.ent[0] = mk_res(DEST_HUB, SEND_DONE, '0, '0);
                    run.ent[1] = mk_res(DEST_DEV, SEND_PROBE, '0, '0);
                end
            end else if (i_item.packet_kind == IN_DATA) begin
                run.cnt    = 2'd1;
                run.ent[0] = mk_res(DEST_DEV, SEND_DATA, i_item.packet_length,
                                    i_item.packet_body & BODY_MASK);
            end
        end
        run.load = o_take;
    end

    assign o_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link  <= 1'b0;
            r_full  <= 1'b0;
            r_asked <= 1'b0;
        end else if (o_take) begin
            r_link  <= n_link;
            r_full  <= n_full;
            r_asked <= n_asked;
        end
    end

    // held packet is only read while the buffer is marked full
    always_ff @(posedge i_clk) begin
        if (o_take && fill) begin
            r_held_len  <= i_item.packet_length;
            r_held_body <= i_item.packet_body[BODY_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/srly_out_seq.sv
// output register that plays out up to three results of one packet
`timescale 1ns / 1ps
`default_nettype none
module srly_out_seq
    import srly_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_run               i_run,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [DATA_W-1:0]       o_data,
    output logic [USER_W-1:0]       o_user,
    output logic                    o_last
);

    logic [1:0]         r_cnt;
    t_res [RUN_MAX-1:0] r_ent;
    logic               pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_free  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign o_data  = {r_ent[0].body, r_ent[0].len};
    assign o_user  = {r_ent[0].kind, r_ent[0].dest};
    assign o_last  = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_run.load && i_run.cnt != 2'd0) begin
            r_cnt <= i_run.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run.load && i_run.cnt != 2'd0) begin
            r_ent <= i_run.ent;
        end else if (pop) begin
            r_ent[0] <= r_ent[1];
            r_ent[1] <= r_ent[2];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/single_buffer_slot_relay.sv
// a packet is registered in the input stage on transfer, its results in the output register
// throughput: one packet per cycle when it causes at most one result and the sink is ready;
//   a packet with more results (up to three) holds the input stage until its last one is taken
// reset: synchronous active-low reset empties both stages and clears the link mode,
//   the buffer-full mark and the slot-requested mark
`timescale 1ns / 1ps
`default_nettype none
module single_buffer_slot_relay
    import srly_pkg::*;
#(
    parameter int BODY_BITS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,   // packet_length, packet_body
    input  wire logic [USER_W-1:0] s_axis_tuser,   // req_type, packet_kind
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // send_length, send_body
    output logic [USER_W-1:0]      m_axis_tuser,   // send_to, send_kind
    output logic                   m_axis_tlast
);

    logic  item_valid;
    t_item item;
    logic  take;
    logic  seq_free;
    t_run  run;

    srly_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_user       (s_axis_tuser),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    srly_core #(
        .BODY_BITS (BODY_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .i_seq_free   (seq_free),
        .o_run        (run)
    );

    srly_out_seq u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run),
        .o_free  (seq_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/core/srly_checker.sv
// port-level checks for the slot relay, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "single_buffer_slot_relay_defines.svh"
module srly_checker
    import srly_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,
    input  wire logic [USER_W-1:0] s_axis_tuser,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [DATA_W-1:0] m_axis_tdata,
    input  wire logic [USER_W-1:0] m_axis_tuser,
    input  wire logic              m_axis_tlast
);

    logic is_poll;
    logic is_slot;
    logic is_data;

    assign is_poll = m_axis_tvalid && (m_axis_tuser[2:1] == SEND_PROBE);
    assign is_slot = m_axis_tvalid && (m_axis_tuser[2:1] == SEND_SLOT);
    assign is_data = m_axis_tvalid && (m_axis_tuser[2:1] == SEND_DATA);

    // nothing comes out in the cycle after reset
    `SRLY_ASSERT_ALWAYS(a_idle_after_reset, !i_rst_n, !m_axis_tvalid)
    // a stalled result stays offered
    `SRLY_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // control packets carry no length and no body
    `SRLY_ASSERT_NOW(a_ctrl_empty, m_axis_tvalid && !is_data, m_axis_tdata == '0)
    // poll goes to the device and always ends a run
    `SRLY_ASSERT_NOW(a_poll_route, is_poll, m_axis_tuser[0] == DEST_DEV && m_axis_tlast)
    // a slot request goes to the hub and is the only result of its packet
    `SRLY_ASSERT_NOW(a_slot_route, is_slot, m_axis_tuser[0] == DEST_HUB && m_axis_tlast)

    logic unused_in;
    assign unused_in = ^{s_axis_tvalid, s_axis_tready, s_axis_tdata, s_axis_tuser};

endmodule

bind single_buffer_slot_relay srly_checker u_srly_checker (.*);
`default_nettype wire

FILE: sim/single_buffer_slot_relay_test.sv
// self-checking testbench for the single buffer slot relay
`timescale 1ns / 1ps
module single_buffer_slot_relay_test;
    import srly_pkg::*;

    localparam int BODY_BITS = 64;
    localparam logic [BODY_W-1:0] BODY_MASK = {BODY_W{1'b1}} >> (BODY_W - BODY_BITS);
    localparam logic [BODY_W-1:0] ONES = {BODY_W{1'b1}};
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_item item;
        bit    typed;
        int    n;
        t_res  r [3];
    } t_step_row;

    typedef struct {
        t_res r;
        logic last;
    } t_due;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic m_tlast;

    single_buffer_slot_relay #(
        .BODY_BITS(BODY_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata),     // packet_length, packet_body
        .s_axis_tuser(s_tuser),     // req_type, packet_kind
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata),     // send_length, send_body
        .m_axis_tuser(m_tuser),     // send_to, send_kind
        .m_axis_tlast(m_tlast)
    );

    // relay state as predicted
    bit lnk_up, buf_full, slot_req;
    logic [LEN_W-1:0] hold_len;
    logic [BODY_W-1:0] hold_body;

    t_due sends_due[$];
    t_step_row steps[$];
    int mismatch_count = 0;
    int sends_checked = 0;
    int items_sent = 0;
    int ignored_sent = 0;
    int busy_items = 0;
    int seg_left = 0;
    int stall_left = 0;
    int sink_g;
    int pick;
    int cyc = 0;
    bit send_calm = 1'b0;
    bit sink_calm = 1'b0;
    t_step_row rnd_row;
    t_due got_due;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_res send_of(t_dest d, t_send_kind k, logic [LEN_W-1:0] l,
                                     logic [BODY_W-1:0] b);
        t_res r;
        r.dest = d;
        r.kind = k;
        r.len = l;
        r.body = b;
        return r;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void relay_step(input t_item it, output t_res outs [3], output int cnt);
        logic [BODY_W-1:0] body;
        cnt = 0;
        body = it.packet_body & BODY_MASK;
        if (it.req_type == DEST_DEV) begin
            if (it.packet_kind == IN_READY) begin
                if (!lnk_up) begin
                    lnk_up = 1'b1;
                    if (!buf_full) begin
                        outs[cnt] = send_of(DEST_DEV, SEND_PROBE, '0, '0);
                        cnt++;
                    end
                end else begin
                    // ready on a live link flushes the held packet
                    buf_full = 1'b0;
                    slot_req = 1'b0;
                    outs[cnt] = send_of(DEST_DEV, SEND_PROBE, '0, '0);
                    cnt++;
                end
            end else if (it.packet_kind == IN_DATA) begin
                lnk_up = 1'b1;
                if (!buf_full) begin
                    hold_len = it.packet_length;
                    hold_body = body;
                    buf_full = 1'b1;
                    if (!slot_req) begin
                        outs[cnt] = send_of(DEST_HUB, SEND_SLOT, '0, '0);
                        cnt++;
                        slot_req = 1'b1;
                    end
                end
            end
        end else if (lnk_up) begin
            if (it.packet_kind == IN_GRANT) begin
                if (buf_full) begin
                    outs[cnt] = send_of(DEST_HUB, SEND_DATA, hold_len, hold_body);
                    cnt++;
                    buf_full = 1'b0;
                end
                slot_req = 1'b0;
                outs[cnt] = send_of(DEST_HUB, SEND_DONE, '0, '0);
                cnt++;
                outs[cnt] = send_of(DEST_DEV, SEND_PROBE, '0, '0);
                cnt++;
            end else if (it.packet_kind == IN_DATA) begin
                outs[cnt] = send_of(DEST_DEV, SEND_DATA, it.packet_length, body);
                cnt++;
            end
        end
    endfunction

    task automatic plan_row(t_dest src, t_in_kind kind, logic [LEN_W-1:0] len,
                            logic [BODY_W-1:0] body, bit typed, int n,
                            t_res r0 = '0, t_res r1 = '0, t_res r2 = '0);
        t_step_row row;
        row.item.req_type = src;
        row.item.packet_kind = kind;
        row.item.packet_length = len;
        row.item.packet_body = body;
        row.typed = typed;
        row.n = n;
        row.r[0] = r0;
        row.r[1] = r1;
        row.r[2] = r2;
        steps.push_back(row);
    endtask

    task report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // called at an edge; returns at the edge where the transfer happens
    task automatic send_packet(t_step_row row);
        t_res outs [3];
        int cnt;
        int gap;
        t_due d;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row.item.packet_body, row.item.packet_length};
        s_tuser <= {row.item.packet_kind, row.item.req_type};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        relay_step(row.item, outs, cnt);
        if (row.typed) begin
            outs = row.r;
            cnt = row.n;
        end
        for (int i = 0; i < cnt; i++) begin
            d.r = outs[i];
            d.last = (i == cnt - 1);
            sends_due.push_back(d);
        end
    endtask

    // sink side back-pressure, alternating calm and choppy stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            sink_calm <= ~sink_calm;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            sink_g = pick_gap(sink_calm);
            m_tready <= (sink_g == 0);
            stall_left <= (sink_g > 0) ? sink_g - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sends_checked++;
            if (sends_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, tuser %h tdata %h",
                                          m_tuser, m_tdata));
            end else begin
                got_due = sends_due.pop_front();
                if (m_tuser[0] !== got_due.r.dest)
                    report_mismatch($sformatf("send_to got %b expected %b",
                                              m_tuser[0], got_due.r.dest));
                if (m_tuser[2:1] !== got_due.r.kind)
                    report_mismatch($sformatf("send_kind got %0d expected %s",
                                              m_tuser[2:1], got_due.r.kind.name()));
                if (m_tdata[LEN_W-1:0] !== got_due.r.len)
                    report_mismatch($sformatf("send_length got %h expected %h",
                                              m_tdata[LEN_W-1:0], got_due.r.len));
                if (m_tdata[DATA_W-1:LEN_W] !== got_due.r.body)
                    report_mismatch($sformatf("send_body got %h expected %h",
                                              m_tdata[DATA_W-1:LEN_W], got_due.r.body));
                if (m_tlast !== got_due.last)
                    report_mismatch($sformatf("last_of_run got %b expected %b",
                                              m_tlast, got_due.last));
            end
        end
    end

    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("single_buffer_slot_relay_test failed");
        $finish;
    end

    initial begin
        // pending link: hub traffic and odd device opcodes do nothing
        plan_row(DEST_HUB, IN_DATA, 8'hFF, ONES, 1, 0);
        plan_row(DEST_HUB, IN_GRANT, 8'h00, '0, 1, 0);
        plan_row(DEST_HUB, IN_READY, 8'h3C, 64'h0F0F_0F0F_0F0F_0F0F, 1, 0);
        plan_row(DEST_HUB, IN_OTHER, 8'hC3, 64'hF0F0_F0F0_F0F0_F0F0, 1, 0);
        plan_row(DEST_DEV, IN_GRANT, 8'h11, 64'h1111_2222_3333_4444, 1, 0);
        plan_row(DEST_DEV, IN_OTHER, 8'h22, 64'h5555_6666_7777_8888, 1, 0);
        // device data while pending wakes the link and asks for a slot
        plan_row(DEST_DEV, IN_DATA, 8'hFF, ONES, 1, 1,
                 send_of(DEST_HUB, SEND_SLOT, '0, '0));
        // buffer full: dropped
        plan_row(DEST_DEV, IN_DATA, 8'h00, '0, 1, 0);
        plan_row(DEST_HUB, IN_GRANT, 8'h00, '0, 1, 3,
                 send_of(DEST_HUB, SEND_DATA, 8'hFF, ONES),
                 send_of(DEST_HUB, SEND_DONE, '0, '0),
                 send_of(DEST_DEV, SEND_PROBE, '0, '0));
        // grant with nothing held
        plan_row(DEST_HUB, IN_GRANT, 8'hFF, ONES, 1, 2,
                 send_of(DEST_HUB, SEND_DONE, '0, '0),
                 send_of(DEST_DEV, SEND_PROBE, '0, '0));
        plan_row(DEST_HUB, IN_DATA, 8'h00, '0, 1, 1,
                 send_of(DEST_DEV, SEND_DATA, 8'h00, '0));
        plan_row(DEST_HUB, IN_DATA, 8'hFF, ONES, 1, 1,
                 send_of(DEST_DEV, SEND_DATA, 8'hFF, ONES));
        plan_row(DEST_HUB, IN_READY, 8'h44, 64'h1234_5678_9ABC_DEF0, 1, 0);
        plan_row(DEST_HUB, IN_OTHER, 8'h55, 64'hFEDC_BA98_7654_3210, 1, 0);
        plan_row(DEST_DEV, IN_GRANT, 8'h66, ONES, 1, 0);
        plan_row(DEST_DEV, IN_OTHER, 8'h77, ONES, 1, 0);
        plan_row(DEST_DEV, IN_DATA, 8'h00, '0, 1, 1,
                 send_of(DEST_HUB, SEND_SLOT, '0, '0));
        // ready on a live link flushes, then again with an empty buffer
        plan_row(DEST_DEV, IN_READY, 8'h00, '0, 1, 1,
                 send_of(DEST_DEV, SEND_PROBE, '0, '0));
        plan_row(DEST_DEV, IN_READY, 8'hFF, ONES, 1, 1,
                 send_of(DEST_DEV, SEND_PROBE, '0, '0));
        plan_row(DEST_DEV, IN_DATA, 8'h5A, 64'hA5A5_5A5A_A5A5_5A5A, 0, 0);
        plan_row(DEST_DEV, IN_DATA, 8'h01, 64'h0123_4567_89AB_CDEF, 0, 0);
        plan_row(DEST_HUB, IN_GRANT, 8'h02, 64'h2, 0, 0);
        plan_row(DEST_HUB, IN_DATA, 8'h80, 64'h8000_0000_0000_0001, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i])
            send_packet(steps[i]);

        // random traffic: mostly meaningful packets, a little noise
        while (busy_items < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 60);
                send_calm = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                rnd_row.item.req_type = DEST_DEV;
                rnd_row.item.packet_kind = IN_DATA;
            end else if (pick < 60) begin
                rnd_row.item.req_type = DEST_HUB;
                rnd_row.item.packet_kind = IN_GRANT;
            end else if (pick < 80) begin
                rnd_row.item.req_type = DEST_HUB;
                rnd_row.item.packet_kind = IN_DATA;
            end else if (pick < 90) begin
                rnd_row.item.req_type = DEST_DEV;
                rnd_row.item.packet_kind = IN_READY;
            end else begin
                rnd_row.item.req_type = t_dest'($urandom_range(0, 1));
                rnd_row.item.packet_kind = t_in_kind'($urandom_range(0, 3));
            end
            pick = $urandom_range(0, 9);
            rnd_row.item.packet_length = (pick == 0) ? 8'h00 :
                                         (pick == 1) ? 8'hFF : LEN_W'($urandom);
            pick = $urandom_range(0, 9);
            rnd_row.item.packet_body = (pick == 0) ? '0 :
                                       (pick == 1) ? ONES : {$urandom, $urandom};
            rnd_row.typed = 1'b0;
            rnd_row.n = 0;
            if ((rnd_row.item.req_type == DEST_DEV && (rnd_row.item.packet_kind == IN_GRANT ||
                                                       rnd_row.item.packet_kind == IN_OTHER)) ||
                (rnd_row.item.req_type == DEST_HUB && (rnd_row.item.packet_kind == IN_READY ||
                                                       rnd_row.item.packet_kind == IN_OTHER)))
                ignored_sent++;
            else
                busy_items++;
            send_packet(rnd_row);
        end
        s_tvalid <= 1'b0;

        while (sends_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d table rows and %0d random packets (%0d of them ignored opcodes)",
                 steps.size(), items_sent - steps.size(), ignored_sent);
        $display("checked %0d relayed packets against the predicted stream, %0d mismatches",
                 sends_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("single_buffer_slot_relay_test passed");
        else
            $display("single_buffer_slot_relay_test failed");
        $finish;
    end

endmodule
